FILE: hw/rtl/qdwc_pkg.sv
// Package for the quadrature decoder with windowed count.
// Holds the direction step codes, the transition lookup and the request kinds.
// No dependencies; imported by qdwc_step, quadrature_decoder_windowed_count and the testbench.
`default_nettype none

package qdwc_pkg;

  // Direction of one encoder transition.
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_e;

  // Step decoded for one sample, passed from the decoder to the counter.
  typedef struct packed {
    logic up;
    logic down;
  } step_t;

  // Request kinds carried in tuser.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Register byte offset of window_ticks (address bit 2 selects the register).
  localparam logic REG_WINDOW_TICKS = 1'b0;

  // Index is {previous state, current state}, each state being {A, B}.
  // Transitions where both channels change count as no motion.
  function automatic step_e step_lookup(input logic [3:0] idx);
    step_e code;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  code = STEP_UP;
      4'd2, 4'd4, 4'd11, 4'd13: code = STEP_DOWN;
      default:                  code = STEP_NONE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/quadrature_decoder_windowed_count.sv
// Quadrature encoder decoder (x4) with windowed velocity or position count.
//
// Input stream: each transfer is either a sample tick (tuser = 0) that carries
// the A and B levels in tdata, or a read request (tuser = 1). Ticks produce no
// output; each read produces one output transfer with the latched signed count.
// Configuration: window_ticks at APB address 0. Nonzero selects window mode,
// where the count is latched and cleared every window_ticks ticks. Zero selects
// position mode, where the count is latched on every tick and a read clears it.
//
// Timing: an accepted item is held in the input register, where it is processed,
// and a read result is then loaded into the output register. One item is taken
// per cycle when the output side keeps up; the single combinational pass
// through the step lookup and count adder sets that rate.
// Stalls: the output register holds a result until it is taken. Ticks keep
// flowing during an output stall; a read waits in the input register, and
// input tready drops only while that read cannot move into the output register.
// Reset clears the count, latch, tick counter, phase history, window_ticks and
// both valid flags.
`default_nettype none

module quadrature_decoder_windowed_count
  import qdwc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] phase_a, [1] phase_b, rest zero
  input  wire logic [0:0]  s_axis_tuser,   // [0] req_type
  // Output stream.
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [((COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata, // count_value, zero fill
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int OutDataW = ((COUNT_WIDTH + 7) / 8) * 8;
  localparam int TickW    = 16;

  // Configuration register.
  logic [TickW-1:0] window_q;

  // Input register.
  logic in_valid_q;
  logic in_req_q;
  logic in_a_q;
  logic in_b_q;

  // Decoder state.
  logic [1:0]             hist_q,  hist_d;
  logic [COUNT_WIDTH-1:0] acc_q,   acc_d;
  logic [COUNT_WIDTH-1:0] latch_q, latch_d;
  logic [TickW-1:0]       ticks_q, ticks_d;

  // Output register.
  logic                   out_valid_q;
  logic [COUNT_WIDTH-1:0] out_data_q;

  logic                   out_free;
  logic                   advance;
  logic                   do_tick;
  logic                   do_read;
  logic                   pos_mode;
  logic                   win_close;
  logic [COUNT_WIDTH-1:0] acc_base;
  logic [COUNT_WIDTH-1:0] step_add;
  logic [1:0]             cur_state;
  step_t                  step;

  // APB access: single register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_TICKS) ? {16'd0, window_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_TICKS) begin
      window_q <= pwdata[TickW-1:0];
    end
  end

  // Handshake: ticks always move on, reads need room in the output register.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && ((in_req_q == REQ_TICK) || out_free);
  assign do_tick       = advance && (in_req_q == REQ_TICK);
  assign do_read       = advance && (in_req_q == REQ_READ);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q <= s_axis_tuser[0];
      in_a_q   <= s_axis_tdata[0];
      in_b_q   <= s_axis_tdata[1];
    end
  end

  // Transition decode.
  qdwc_step u_step (
    .hist_i    (hist_q),
    .phase_a_i (in_a_q),
    .phase_b_i (in_b_q),
    .cur_o     (cur_state),
    .step_o    (step)
  );

  // Count update: window close test, step added to the base, latch, read clear.
  always_comb begin
    pos_mode  = (window_q == '0);
    win_close = !pos_mode && (ticks_q >= window_q);
    acc_base  = win_close ? '0 : acc_q;
    step_add  = step.up ? COUNT_WIDTH'(1) : (step.down ? '1 : '0);

    hist_d  = hist_q;
    acc_d   = acc_q;
    latch_d = latch_q;
    ticks_d = ticks_q;
    if (do_tick) begin
      hist_d = cur_state;
      acc_d  = acc_base + step_add;
      if (pos_mode || win_close) begin
        latch_d = acc_q;
      end
      if (pos_mode) begin
        ticks_d = '0;
      end else begin
        ticks_d = (win_close ? '0 : ticks_q) + TickW'(1);
      end
    end else if (do_read && pos_mode) begin
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      acc_q   <= '0;
      latch_q <= '0;
      ticks_q <= '0;
    end else begin
      hist_q  <= hist_d;
      acc_q   <= acc_d;
      latch_q <= latch_d;
      ticks_q <= ticks_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_read) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_read) begin
      out_data_q <= latch_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);

  // A read that moves on shows the latched count in the next cycle.
  a_read_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_read |=> (m_axis_tvalid && out_data_q == $past(latch_q)))
    else $error("read result not loaded from latched count");

  // A read never overwrites a result that is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_read |-> (!out_valid_q || m_axis_tready))
    else $error("read advanced into a stalled output register");

  // Input ready drops only while the input register holds a blocked read.
  a_ready_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_req_q == REQ_READ && !out_free))
    else $error("input stalled without a blocked read");

  // In position mode a tick leaves the tick counter at zero.
  a_pos_ticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_tick && pos_mode) |=> (ticks_q == '0))
    else $error("tick counter moved in position mode");

  // A tick leaves a waiting result untouched.
  a_tick_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_tick && out_valid_q && !m_axis_tready) |=> (m_axis_tvalid && $stable(out_data_q)))
    else $error("tick disturbed a stalled result");

endmodule

`default_nettype wire

FILE: hw/rtl/qdwc_step.sv
// Quadrature transition decoder: turns the previous and current A/B state
// into an up or down step. Depends on qdwc_pkg for the lookup and step_t.
`default_nettype none

module qdwc_step
  import qdwc_pkg::*;
(
  input  wire logic [1:0] hist_i,
  input  wire logic       phase_a_i,
  input  wire logic       phase_b_i,
  output      logic [1:0] cur_o,
  output      step_t      step_o
);

  step_e code;

  // Current state is B plus twice A.
  assign cur_o = {phase_a_i, phase_b_i};

  // Look up the direction of the transition from the stored state.
  always_comb begin
    code        = step_lookup({hist_i, cur_o});
    step_o.up   = (code == STEP_UP);
    step_o.down = (code == STEP_DOWN);
  end

endmodule

`default_nettype wire

FILE: bench/quadrature_decoder_windowed_count_tb.sv
// Self-checking testbench for quadrature_decoder_windowed_count.
// Drives sample ticks and read requests, programs window_ticks over APB and
// compares each count_value against a cycle-free predictor; needs qdwc_pkg.
module quadrature_decoder_windowed_count_tb;
  import qdwc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 500;
  localparam logic [2:0] ADDR_WINDOW = {REG_WINDOW_TICKS, 2'b00};
  localparam logic [2:0] ADDR_UNUSED = {~REG_WINDOW_TICKS, 2'b00};

  // Direction of each transition, indexed by {previous {A,B}, current {A,B}}.
  localparam step_e DIR_OF_MOVE [16] = '{
    STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE,
    STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
    STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
    STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE
  };

  typedef struct packed {
    logic       req;
    logic [1:0] ab;      // {A, B}
    bit         typed;   // count_value below is the known answer
    logic [15:0] val;
  } dir_row_t;

  typedef struct packed {
    bit          typed;
    logic [15:0] val;
  } known_t;

  // Directed rows: every one of the 16 transitions, back-to-back reads, and a
  // read straight after reset. Window mode is off (reset value).
  localparam dir_row_t DIR_TAB [24] = '{
    '{REQ_READ, 2'b00, 1'b1, 16'd0},
    '{REQ_TICK, 2'b00, 1'b0, 16'd0},
    '{REQ_TICK, 2'b01, 1'b0, 16'd0},
    '{REQ_TICK, 2'b11, 1'b0, 16'd0},
    '{REQ_READ, 2'b00, 1'b0, 16'd0},
    '{REQ_TICK, 2'b10, 1'b0, 16'd0},
    '{REQ_TICK, 2'b00, 1'b0, 16'd0},
    '{REQ_TICK, 2'b10, 1'b0, 16'd0},
    '{REQ_TICK, 2'b11, 1'b0, 16'd0},
    '{REQ_TICK, 2'b01, 1'b0, 16'd0},
    '{REQ_TICK, 2'b00, 1'b0, 16'd0},
    '{REQ_TICK, 2'b11, 1'b0, 16'd0},
    '{REQ_TICK, 2'b00, 1'b0, 16'd0},
    '{REQ_TICK, 2'b01, 1'b0, 16'd0},
    '{REQ_TICK, 2'b10, 1'b0, 16'd0},
    '{REQ_TICK, 2'b01, 1'b0, 16'd0},
    '{REQ_TICK, 2'b01, 1'b0, 16'd0},
    '{REQ_READ, 2'b10, 1'b0, 16'd0},
    '{REQ_READ, 2'b11, 1'b0, 16'd0},
    '{REQ_TICK, 2'b11, 1'b0, 16'd0},
    '{REQ_TICK, 2'b11, 1'b0, 16'd0},
    '{REQ_TICK, 2'b10, 1'b0, 16'd0},
    '{REQ_TICK, 2'b10, 1'b0, 16'd0},
    '{REQ_READ, 2'b00, 1'b0, 16'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] phase_a, [1] phase_b, rest zero
  logic [0:0]  s_axis_tuser = '0;   // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] count_value
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  quadrature_decoder_windowed_count u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predicted decoder state and configuration.
  logic [15:0] win_ticks = '0;
  logic [15:0] tick_cnt = '0;
  logic [1:0]  prev_ab = '0;
  logic [15:0] pos_acc = '0;
  logic [15:0] latch_val = '0;

  logic [15:0] count_exp_q [$];
  known_t      known_q [$];
  int          err_cnt = 0;
  int          idle_cycles = 0;
  int          item_cnt = 0;
  bit          burst = 1'b0;     // no idling on either side while set
  logic [1:0]  gen_ab = '0;      // encoder levels last sent on a tick

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Apply one transition to the predicted accumulator.
  task automatic apply_motion(input logic [1:0] cur_ab);
    case (DIR_OF_MOVE[{prev_ab, cur_ab}])
      STEP_UP:   pos_acc = pos_acc + 16'd1;
      STEP_DOWN: pos_acc = pos_acc - 16'd1;
      default: ;
    endcase
    prev_ab = cur_ab;
  endtask

  // Predict one accepted item; a read yields one count_value.
  task automatic qdec_predict(input logic req, input logic [1:0] ab,
                              output bit has_res, output logic [15:0] res);
    has_res = 1'b0;
    res = '0;
    if (req == REQ_READ) begin
      has_res = 1'b1;
      res = latch_val;
      if (win_ticks == '0) pos_acc = '0;
    end else if (win_ticks == '0) begin
      latch_val = pos_acc;
      apply_motion(ab);
      tick_cnt = '0;
    end else begin
      // A shortened window closes on the next tick.
      if (tick_cnt >= win_ticks) begin
        latch_val = pos_acc;
        pos_acc = '0;
        tick_cnt = '0;
      end
      apply_motion(ab);
      tick_cnt = tick_cnt + 16'd1;
    end
  endtask

  // Watch all three ports at each edge: check results, predict inputs.
  always @(posedge clk_i) begin
    bit          has_res;
    logic [15:0] res;
    known_t      known;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (count_exp_q.size() == 0) begin
          report($sformatf("count_value %0d with no read pending",
                           $signed(m_axis_tdata)));
        end else begin
          res = count_exp_q.pop_front();
          if (m_axis_tdata !== res) begin
            report($sformatf("count_value expected %0d got %0d",
                             $signed(res), $signed(m_axis_tdata)));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        known = (known_q.size() != 0) ? known_q.pop_front() : '0;
        qdec_predict(s_axis_tuser[0], {s_axis_tdata[0], s_axis_tdata[1]}, has_res, res);
        if (has_res) count_exp_q.push_back(known.typed ? known.val : res);
      end
      if (psel && penable && pready) begin
        if (pwrite && paddr == ADDR_WINDOW) begin
          win_ticks = pwdata[15:0];
        end else if (!pwrite && paddr == ADDR_WINDOW && prdata[15:0] !== win_ticks) begin
          report($sformatf("window_ticks read back %0d, written %0d",
                           prdata[15:0], win_ticks));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Result side: after each transfer, insert a random tready stall unless burst is set.
  always @(posedge clk_i) begin
    int stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        stall = burst ? 0 : $urandom_range(0, 4);
      end else if (stall != 0) begin
        stall--;
      end
      m_axis_tready <= (stall == 0);
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [1:0] next_ab(input logic [1:0] ab, input bit up);
    case (ab)
      2'b00:   return up ? 2'b01 : 2'b10;
      2'b01:   return up ? 2'b11 : 2'b00;
      2'b11:   return up ? 2'b10 : 2'b01;
      default: return up ? 2'b00 : 2'b11;
    endcase
  endfunction

  // Send one item after a random gap and wait for its transfer.
  task automatic push_item(input logic req, input logic [1:0] ab,
                           input bit typed, input logic [15:0] val);
    int gap;
    item_cnt++;
    if (item_cnt % 256 == 0) burst = ($urandom_range(0, 3) == 0);
    gap = burst ? 0 : $urandom_range(0, 4);
    known_q.push_back(known_t'{typed, val});
    if (req == REQ_TICK) gen_ab = ab;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {6'b0, ab[0], ab[1]};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every read has answered and ticks have drained.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (count_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write, then read window_ticks back.
  task automatic program_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_WINDOW;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly legal encoder motion with a drift, some glitches, and reads.
  task automatic random_phase(input int n, input int rd_per_mille);
    int bias;
    int r;
    int m;
    bias = $urandom_range(0, 2);
    burst = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      r = $urandom_range(0, 999);
      m = $urandom_range(0, 9);
      if (r < rd_per_mille) begin
        push_item(REQ_READ, 2'($urandom_range(0, 3)), 1'b0, '0);
      end else if (r < rd_per_mille + 80) begin
        push_item(REQ_TICK, 2'($urandom_range(0, 3)), 1'b0, '0);
      end else if (m >= 8) begin
        push_item(REQ_TICK, gen_ab, 1'b0, '0);
      end else begin
        case (bias)
          0:       push_item(REQ_TICK, next_ab(gen_ab, m < 4), 1'b0, '0);
          1:       push_item(REQ_TICK, next_ab(gen_ab, m < 6), 1'b0, '0);
          default: push_item(REQ_TICK, next_ab(gen_ab, m >= 6), 1'b0, '0);
        endcase
      end
    end
  endtask

  function automatic logic [15:0] draw_window();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'($urandom_range(1, 4));
      2:       return 16'($urandom_range(5, 60));
      default: return 16'hFFFF - 16'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TAB[i]) begin
      push_item(DIR_TAB[i].req, DIR_TAB[i].ab, DIR_TAB[i].typed, DIR_TAB[i].val);
    end
    settle();

    program_reg(ADDR_WINDOW, 32'd3);
    random_phase(90, 180);
    settle();
    program_reg(ADDR_WINDOW, 32'd1);
    random_phase(90, 180);
    settle();
    // Writes outside the register map leave window_ticks alone.
    program_reg(ADDR_UNUSED, $urandom);
    random_phase(40, 180);
    settle();
    // Widen the window, then shrink it in the middle of a count.
    program_reg(ADDR_WINDOW, 32'd40);
    random_phase(30, 100);
    settle();
    program_reg(ADDR_WINDOW, 32'd2);
    random_phase(40, 180);
    settle();
    repeat (5) begin
      program_reg(ADDR_WINDOW, {16'd0, draw_window()});
      random_phase(70, 180);
      settle();
    end

    program_reg(ADDR_WINDOW, {16'd0, draw_window()});
    random_phase(100, 180);
    settle();

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: quadrature_decoder_windowed_count.f
hw/rtl/qdwc_pkg.sv
hw/rtl/qdwc_step.sv
hw/rtl/quadrature_decoder_windowed_count.sv
bench/quadrature_decoder_windowed_count_tb.sv
